>>> rtl/core/tti_pkg.sv
// Package for the time table interpolator: widths, action and status codes,
// item structs and the sequencer state type. No dependencies.
package tti_pkg;

  localparam int MaxRowsDefault    = 1024;
  localparam int NumColumnsDefault = 4;

  localparam int DataW   = 32;
  localparam int ActionW = 3;
  localparam int ColumnW = 2;
  localparam int RowW    = 10;
  localparam int StatusW = 2;

  localparam logic [ActionW-1:0] ActAppend = 3'd0;
  localparam logic [ActionW-1:0] ActWrite  = 3'd1;
  localparam logic [ActionW-1:0] ActLerp   = 3'd2;
  localparam logic [ActionW-1:0] ActHold   = 3'd3;
  localparam logic [ActionW-1:0] ActClear  = 3'd4;

  localparam logic [StatusW-1:0] StOk    = 2'd0;
  localparam logic [StatusW-1:0] StEmpty = 2'd1;
  localparam logic [StatusW-1:0] StFull  = 2'd2;
  localparam logic [StatusW-1:0] StRange = 2'd3;

  // input item
  typedef struct packed {
    logic [ActionW-1:0]      action;
    logic [ColumnW-1:0]      column;
    logic [RowW-1:0]         row_index;
    logic signed [DataW-1:0] time_q;
    logic signed [DataW-1:0] sample_value;
  } cmd_t;

  // result item
  typedef struct packed {
    logic [StatusW-1:0]      status;
    logic signed [DataW-1:0] result_value;
    logic [RowW-1:0]         found_row;
  } answer_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RD_FIRST,   // read t[0]
    S_CHK_FIRST,  // compare against first time
    S_CHK_LAST,   // compare against last time
    S_SRCH_RD,    // issue read of t[mid]
    S_SRCH_CMP,   // compare and narrow
    S_RD_TL,      // read t[l]
    S_RD_TU,      // read t[u], capture t[l]
    S_GOT_TU,     // capture t[u], form d, n
    S_RD_SL,      // read s[l]
    S_RD_SU,      // read s[u], capture s[l]
    S_GOT_SU,     // capture s[u], form delta
    S_DIV,        // one quotient bit per cycle
    S_MUL,        // |delta| * r
    S_FINISH,     // round, sign, saturate
    S_RD_SMP,     // read a single sample for a direct answer
    S_GOT_SMP,
    S_OUT
  } tti_state_t;

endpackage

>>> rtl/core/tti_stream_if.sv
// Valid/ready channel carrying one payload struct or vector.
// Depends on nothing.
interface tti_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/core/time_table_interpolator.sv
// Time table interpolator: Q16.16 time/sample table, binary search, lerp.
// Append, write, clear and errors give their result in the cycle after acceptance;
// queries check t[0], t[last], search (k <= 10 steps at 1024 rows) on one time
// read port, read a sample, or for lerp t[l], t[u], s[l], s[u] and, if not degenerate,
// do a 32-step divide and one 32x32 multiply. Next item accepted once result is taken.
// Synchronous reset empties the table and the result register; stores keep data.
module time_table_interpolator #(
  parameter int MaxRows    = tti_pkg::MaxRowsDefault,
  parameter int NumColumns = tti_pkg::NumColumnsDefault
) (
  input logic clk,
  input logic rst,
  tti_stream_if.sink   in_ch,
  tti_stream_if.source out_ch
);
  localparam int AW   = $clog2(MaxRows);
  localparam int CntW = $clog2(MaxRows + 1);
  localparam int CW   = (NumColumns > 1) ? $clog2(NumColumns) : 1;
  localparam int SAW  = AW + CW;
  localparam int DW   = tti_pkg::DataW;

  // incoming item fields
  logic [tti_pkg::ActionW-1:0] a_action;
  logic [tti_pkg::ColumnW-1:0] a_column;
  logic [tti_pkg::RowW-1:0]    a_row;
  logic signed [DW-1:0]        a_time, a_sample;
  assign a_action = in_ch.payload.action;
  assign a_column = in_ch.payload.column;
  assign a_row    = in_ch.payload.row_index;
  assign a_time   = in_ch.payload.time_q;
  assign a_sample = in_ch.payload.sample_value;

  tti_pkg::tti_state_t state, state_next;

  logic [CntW-1:0] row_count;
  logic [tti_pkg::ActionW-1:0] action;
  logic [CW-1:0] col;
  logic signed [DW-1:0] qt;
  logic [AW-1:0] lo, hi, lrow, urow, last;

  // shared datapath registers
  logic signed [DW:0] tl, d, n;     // 33-bit differences
  logic signed [DW-1:0] sl;
  logic signed [DW:0] delta;
  logic [DW-1:0] mag, quo;
  logic [DW:0] rem;
  logic [5:0] cnt;
  logic [2*DW-1:0] prod;

  // result register
  logic [tti_pkg::StatusW-1:0] o_status;
  logic signed [DW-1:0] o_value;
  logic [tti_pkg::RowW-1:0] o_row;
  logic o_valid;

  // stores
  logic t_we, s_we;
  logic [AW-1:0] t_addr, rd_row;
  logic [SAW-1:0] s_addr;
  logic [DW-1:0] t_rdata, s_rdata;
  logic [DW-1:0] t_wdata, s_wdata;

  tti_ram #(.Width(DW), .Depth(MaxRows)) u_time (
    .clk(clk), .we(t_we), .addr(t_addr), .wdata(t_wdata), .rdata(t_rdata)
  );
  tti_ram #(.Width(DW), .Depth(MaxRows * (2 ** CW))) u_smp (
    .clk(clk), .we(s_we), .addr(s_addr), .wdata(s_wdata), .rdata(s_rdata)
  );

  logic accept;
  assign in_ch.ready = (state == tti_pkg::S_IDLE) && !o_valid;
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = o_valid;
  assign out_ch.payload.status       = o_status;
  assign out_ch.payload.result_value = o_value;
  assign out_ch.payload.found_row    = o_row;

  logic col_ok, row_ok;
  assign col_ok = {{(32-tti_pkg::ColumnW){1'b0}}, a_column} < NumColumns;
  assign row_ok = {{(32-tti_pkg::RowW){1'b0}}, a_row} < 32'(row_count);

  logic signed [DW:0] t_ext;
  assign t_ext = {t_rdata[DW-1], t_rdata};
  logic signed [DW:0] q_ext;
  assign q_ext = {qt[DW-1], qt};
  logic [AW-1:0] mid;
  assign mid = lo + ((hi - lo) >> 1);

  // divider step: shift remainder, subtract divisor
  logic [DW+1:0] rem_sh, rem_sub;
  assign rem_sh  = {rem, 1'b0};
  assign rem_sub = rem_sh - {1'b0, d};

  // shared 32x32 multiplier, mag times quotient
  logic [DW-1:0] mul_a, mul_b;
  logic [2*DW-1:0] mul_p;
  assign mul_a = mag;
  assign mul_b = quo;
  assign mul_p = mul_a * mul_b;

  // final rounding and saturation
  logic [2*DW-1:0] rnd;
  logic signed [DW+1:0] res;
  assign rnd = prod + 64'h8000_0000;
  assign res = delta[DW] ? ({{2{sl[DW-1]}}, sl} - {2'b00, rnd[2*DW-1:DW]})
                         : ({{2{sl[DW-1]}}, sl} + {2'b00, rnd[2*DW-1:DW]});

  // memory address and write control
  always_comb begin
    t_we    = 1'b0;
    s_we    = 1'b0;
    t_wdata = a_time;
    s_wdata = a_sample;
    t_addr  = rd_row;
    s_addr  = {rd_row, col};
    if (accept) begin
      t_addr = row_count[AW-1:0];
      s_addr = {AW'(a_row), CW'(a_column)};
      if (a_action == tti_pkg::ActAppend && 32'(row_count) < MaxRows) begin
        t_we = 1'b1;
      end
      if (a_action == tti_pkg::ActWrite && row_count != '0 && col_ok && row_ok) begin
        s_we = 1'b1;
      end
    end
  end

  // row driven onto the read ports per state
  always_comb begin
    case (state)
      tti_pkg::S_RD_FIRST: rd_row = '0;
      tti_pkg::S_CHK_FIRST: rd_row = last;
      tti_pkg::S_SRCH_RD:  rd_row = mid;
      tti_pkg::S_RD_TL, tti_pkg::S_RD_SL: rd_row = lrow;
      tti_pkg::S_RD_TU, tti_pkg::S_RD_SU: rd_row = urow;
      tti_pkg::S_RD_SMP:   rd_row = lrow;
      default:             rd_row = lrow;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tti_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      tti_pkg::S_IDLE: begin
        if (accept && (a_action == tti_pkg::ActLerp || a_action == tti_pkg::ActHold)
            && row_count != '0 && col_ok) begin
          state_next = tti_pkg::S_RD_FIRST;
        end
      end
      tti_pkg::S_RD_FIRST:  state_next = tti_pkg::S_CHK_FIRST;
      tti_pkg::S_CHK_FIRST: begin
        if (last == '0 || q_ext <= t_ext) state_next = tti_pkg::S_RD_SMP;
        else state_next = tti_pkg::S_CHK_LAST;
      end
      tti_pkg::S_CHK_LAST: begin
        if (q_ext >= t_ext) state_next = tti_pkg::S_RD_SMP;
        else if (lo < hi) state_next = tti_pkg::S_SRCH_RD;
        else if (action == tti_pkg::ActLerp) state_next = tti_pkg::S_RD_TL;
        else state_next = tti_pkg::S_RD_SMP;
      end
      tti_pkg::S_SRCH_RD: state_next = tti_pkg::S_SRCH_CMP;
      tti_pkg::S_SRCH_CMP: begin
        if ((t_ext <= q_ext) ? (mid + 1'b1 < hi) : (lo < mid)) begin
          state_next = tti_pkg::S_SRCH_RD;
        end else if (action == tti_pkg::ActLerp) begin
          state_next = tti_pkg::S_RD_TL;
        end else begin
          state_next = tti_pkg::S_RD_SMP;
        end
      end
      tti_pkg::S_RD_TL:  state_next = tti_pkg::S_RD_TU;
      tti_pkg::S_RD_TU:  state_next = tti_pkg::S_GOT_TU;
      tti_pkg::S_GOT_TU: state_next = tti_pkg::S_RD_SL;
      tti_pkg::S_RD_SL:  state_next = tti_pkg::S_RD_SU;
      tti_pkg::S_RD_SU:  state_next = tti_pkg::S_GOT_SU;
      tti_pkg::S_GOT_SU: begin
        if (d <= 0 || n >= d || n < 0) state_next = tti_pkg::S_OUT;
        else state_next = tti_pkg::S_DIV;
      end
      tti_pkg::S_DIV:    state_next = (cnt == 6'd31) ? tti_pkg::S_MUL : tti_pkg::S_DIV;
      tti_pkg::S_MUL:    state_next = tti_pkg::S_FINISH;
      tti_pkg::S_FINISH: state_next = tti_pkg::S_OUT;
      tti_pkg::S_RD_SMP: state_next = tti_pkg::S_GOT_SMP;
      tti_pkg::S_GOT_SMP: state_next = tti_pkg::S_OUT;
      tti_pkg::S_OUT:    state_next = tti_pkg::S_IDLE;
      default:           state_next = tti_pkg::S_IDLE;
    endcase
  end

  // control: row count and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      o_valid   <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) o_valid <= 1'b0;
      if (accept) begin
        if (a_action == tti_pkg::ActAppend && 32'(row_count) < MaxRows) begin
          row_count <= row_count + 1'b1;
        end
        if (a_action == tti_pkg::ActClear) row_count <= '0;
        if (!(a_action == tti_pkg::ActLerp || a_action == tti_pkg::ActHold)
            || row_count == '0 || !col_ok) begin
          o_valid <= 1'b1;
        end
      end
      if (state == tti_pkg::S_OUT) o_valid <= 1'b1;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      tti_pkg::S_IDLE: begin
        if (accept) begin
          action   <= a_action;
          col      <= CW'(a_column);
          qt       <= a_time;
          last     <= AW'(row_count - 1'b1);
          lo       <= AW'(1);
          hi       <= AW'(row_count - 1'b1);
          lrow     <= '0;
          o_value  <= '0;
          o_row    <= '0;
          o_status <= tti_pkg::StOk;
          if (a_action == tti_pkg::ActAppend) begin
            if (32'(row_count) >= MaxRows) o_status <= tti_pkg::StFull;
          end else if (a_action == tti_pkg::ActWrite) begin
            if (row_count == '0) o_status <= tti_pkg::StEmpty;
            else if (!col_ok || !row_ok) o_status <= tti_pkg::StRange;
          end else if (a_action == tti_pkg::ActLerp || a_action == tti_pkg::ActHold) begin
            if (row_count == '0) o_status <= tti_pkg::StEmpty;
            else if (!col_ok) o_status <= tti_pkg::StRange;
          end
        end
      end
      tti_pkg::S_CHK_FIRST: begin
        if (!(last == '0 || q_ext <= t_ext)) lrow <= last;
      end
      tti_pkg::S_CHK_LAST: begin
        if (!(q_ext >= t_ext)) begin
          lrow <= AW'(lo - 1'b1);
          urow <= lo;
        end
      end
      tti_pkg::S_SRCH_CMP: begin
        if (t_ext <= q_ext) begin
          lo   <= mid + 1'b1;
          lrow <= mid;
          urow <= mid + 1'b1;
        end else begin
          hi   <= mid;
          lrow <= AW'(lo - 1'b1);
          urow <= lo;
        end
      end
      tti_pkg::S_RD_TU:  tl <= t_ext;
      tti_pkg::S_GOT_TU: begin
        d <= t_ext - tl;
        n <= q_ext - tl;
      end
      tti_pkg::S_RD_SU:  sl <= $signed(s_rdata);
      tti_pkg::S_GOT_SU: begin
        delta <= {s_rdata[DW-1], s_rdata} - {sl[DW-1], sl};
        rem   <= n;
        quo   <= '0;
        cnt   <= '0;
        o_row <= tti_pkg::RowW'(lrow);
        if (d <= 0 || n >= d) o_value <= $signed(s_rdata);
        else if (n < 0) o_value <= sl;
      end
      tti_pkg::S_DIV: begin
        cnt <= cnt + 1'b1;
        if (cnt == 6'd0) mag <= delta[DW] ? DW'(-delta) : DW'(delta);
        if (!rem_sub[DW+1]) begin
          rem <= rem_sub[DW:0];
          quo <= {quo[DW-2:0], 1'b1};
        end else begin
          rem <= rem_sh[DW:0];
          quo <= {quo[DW-2:0], 1'b0};
        end
      end
      tti_pkg::S_MUL: prod <= mul_p;
      tti_pkg::S_FINISH: begin
        if (res > $signed({2'b00, 32'h7FFF_FFFF})) o_value <= 32'h7FFF_FFFF;
        else if (res < -$signed({2'b00, 32'h8000_0000})) o_value <= 32'h8000_0000;
        else o_value <= res[DW-1:0];
      end
      tti_pkg::S_GOT_SMP: begin
        o_value <= $signed(s_rdata);
        o_row   <= tti_pkg::RowW'(lrow);
      end
      default: ;
    endcase
  end

  // checks
  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    state != tti_pkg::S_IDLE |-> !in_ch.ready) else $error("ready while busy");
  a_out_after_seq: assert property (@(posedge clk) disable iff (rst)
    state == tti_pkg::S_OUT |=> out_ch.valid) else $error("result lost");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(row_count) <= MaxRows) else $error("row count overflow");
  a_search_order: assert property (@(posedge clk) disable iff (rst)
    state == tti_pkg::S_SRCH_RD |-> lo < hi) else $error("search window empty");
endmodule

>>> rtl/core/tti_ram.sv
// Generic single-port RAM with registered read.
// Depends on nothing.
module tti_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
